@@ rtl/core/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

  localparam int CB  = 32;          // coordinate width, signed Q16.16
  localparam int DW  = CB + 1;      // coordinate difference
  localparam int PW  = 2 * DW;      // product of two differences
  localparam int SW  = PW + 1;      // sum of two products
  localparam int PPW = DW + 1 + CB; // partial product of weight and coordinate
  localparam int NW  = SW + CB;     // weighted coordinate sum
  localparam int QB  = CB;          // quotient bits

  localparam logic [1:0] REGION_VERTEX = 2'd0;
  localparam logic [1:0] REGION_EDGE   = 2'd1;
  localparam logic [1:0] REGION_INSIDE = 2'd2;

  localparam logic [2:0] KEEP_A   = 3'b001;
  localparam logic [2:0] KEEP_B   = 3'b010;
  localparam logic [2:0] KEEP_C   = 3'b100;
  localparam logic [2:0] KEEP_AB  = 3'b011;
  localparam logic [2:0] KEEP_BC  = 3'b110;
  localparam logic [2:0] KEEP_CA  = 3'b101;
  localparam logic [2:0] KEEP_ALL = 3'b111;

endpackage

@@ rtl/core/scp_if.sv @@
`timescale 1ns / 1ps
interface scp_in_if
  import scp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           vertex_count;
  logic signed [CB-1:0] vertex_a_x;
  logic signed [CB-1:0] vertex_a_y;
  logic signed [CB-1:0] vertex_b_x;
  logic signed [CB-1:0] vertex_b_y;
  logic signed [CB-1:0] vertex_c_x;
  logic signed [CB-1:0] vertex_c_y;
  logic signed [CB-1:0] query_x;
  logic signed [CB-1:0] query_y;

  modport source (
    output valid, vertex_count, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_count, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    output ready
  );
endinterface

interface scp_out_if
  import scp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] nearest_x;
  logic signed [CB-1:0] nearest_y;
  logic signed [DW-1:0] direction_x;
  logic signed [DW-1:0] direction_y;
  logic [1:0]           region;
  logic [2:0]           keep_mask;

  modport source (
    output valid, nearest_x, nearest_y, direction_x, direction_y, region, keep_mask,
    input  ready
  );
  modport sink (
    input  valid, nearest_x, nearest_y, direction_x, direction_y, region, keep_mask,
    output ready
  );
endinterface

@@ rtl/core/simplex_closest_point_2d.sv @@
`timescale 1ns / 1ps
// Closest point of a 2-D simplex (point, segment or triangle) to a query point,
// with Voronoi region, next search direction and keep mask. Fully pipelined:
// one item per cycle. The depth is set by the restoring divider for the edge
// point, one quotient bit per stage; differences, 33x33 products, sums, region
// select, split weight products, sum and magnitude take the seven stages
// before it. A stall at the output freezes the whole pipe.
module simplex_closest_point_2d
  import scp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  scp_in_if.sink   in_i,
  scp_out_if.source out_o
);

  localparam int NS = 8 + QB;
  localparam int NP = 26;
  localparam int NSUM = 13;
  localparam int UAB = 0, VAB = 1, DAB = 2, UBC = 3, VBC = 4, DBC = 5;
  localparam int UCA = 6, VCA = 7, DCA = 8, TU = 9, TV = 10, TW = 11, TD = 12;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, qx, qy;
    vec_t                 qa, qb, qc, ab, ba, bc, cb, ca, ac;
  } geo_t;

  typedef struct packed {
    logic                 is_edge;
    logic [1:0]           region;
    logic [2:0]           keep;
    logic signed [CB-1:0] nx, ny;
    logic signed [DW-1:0] dx, dy;
  } info_t;

  typedef enum logic [2:0] {
    SEL_VA, SEL_VB, SEL_VC, SEL_EAB, SEL_EBC, SEL_ECA, SEL_IN
  } sel_e;

  function automatic logic signed [DW-1:0] sub_f(logic signed [CB-1:0] p,
                                                 logic signed [CB-1:0] m);
    return DW'(p) - DW'(m);
  endfunction

  logic en;
  logic [NS-1:0] v_q;

  geo_t g1_q, g2_q, g3_q, g1_d;
  logic signed [PW-1:0] pr_q [NP];
  logic signed [DW-1:0] opa [NP];
  logic signed [DW-1:0] opb [NP];
  logic signed [SW-1:0] sm_q [NSUM];

  info_t inf4_q, inf5_q, inf6_q, inf4_d;
  info_t info_q [QB+1];
  logic [SW-2:0] u4_q, v4_q, dv4_q, dv5_q, dv6_q, u4_d, v4_d, dv4_d;
  logic [SW-2:0] dv_q [QB];
  logic signed [CB-1:0] c0x_q, c0y_q, c1x_q, c1y_q, c0x_d, c0y_d, c1x_d, c1y_d;
  logic signed [PPW-1:0] pp_q [8];
  logic signed [NW-1:0] numx_q, numy_q;
  logic [NW-1:0] remx_q [QB+1];
  logic [NW-1:0] remy_q [QB+1];
  logic [CB-1:0] quox_q [QB+1];
  logic [CB-1:0] quoy_q [QB+1];
  logic negx_q [QB+1];
  logic negy_q [QB+1];

  logic signed [CB-1:0] nx_q, ny_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [1:0] rg_q;
  logic [2:0] kp_q;

  assign en = !v_q[NS-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_i.valid};
    end
  end

  // stage 1: differences
  always_comb begin
    g1_d.cnt = in_i.vertex_count;
    g1_d.ax = in_i.vertex_a_x; g1_d.ay = in_i.vertex_a_y;
    g1_d.bx = in_i.vertex_b_x; g1_d.by = in_i.vertex_b_y;
    g1_d.cx = in_i.vertex_c_x; g1_d.cy = in_i.vertex_c_y;
    g1_d.qx = in_i.query_x;    g1_d.qy = in_i.query_y;
    g1_d.qa = '{x: sub_f(in_i.query_x, in_i.vertex_a_x), y: sub_f(in_i.query_y, in_i.vertex_a_y)};
    g1_d.qb = '{x: sub_f(in_i.query_x, in_i.vertex_b_x), y: sub_f(in_i.query_y, in_i.vertex_b_y)};
    g1_d.qc = '{x: sub_f(in_i.query_x, in_i.vertex_c_x), y: sub_f(in_i.query_y, in_i.vertex_c_y)};
    g1_d.ab = '{x: sub_f(in_i.vertex_a_x, in_i.vertex_b_x),
                y: sub_f(in_i.vertex_a_y, in_i.vertex_b_y)};
    g1_d.ba = '{x: sub_f(in_i.vertex_b_x, in_i.vertex_a_x),
                y: sub_f(in_i.vertex_b_y, in_i.vertex_a_y)};
    g1_d.bc = '{x: sub_f(in_i.vertex_b_x, in_i.vertex_c_x),
                y: sub_f(in_i.vertex_b_y, in_i.vertex_c_y)};
    g1_d.cb = '{x: sub_f(in_i.vertex_c_x, in_i.vertex_b_x),
                y: sub_f(in_i.vertex_c_y, in_i.vertex_b_y)};
    g1_d.ca = '{x: sub_f(in_i.vertex_c_x, in_i.vertex_a_x),
                y: sub_f(in_i.vertex_c_y, in_i.vertex_a_y)};
    g1_d.ac = '{x: sub_f(in_i.vertex_a_x, in_i.vertex_c_x),
                y: sub_f(in_i.vertex_a_y, in_i.vertex_c_y)};
  end

  // stage 2 operands: dot(p,r) = px*rx + py*ry, cross(p,r) = px*ry - py*rx
  always_comb begin
    opa[2*UAB] = g1_q.qb.x; opb[2*UAB] = g1_q.ab.x; opa[2*UAB+1] = g1_q.qb.y; opb[2*UAB+1] = g1_q.ab.y;
    opa[2*VAB] = g1_q.qa.x; opb[2*VAB] = g1_q.ba.x; opa[2*VAB+1] = g1_q.qa.y; opb[2*VAB+1] = g1_q.ba.y;
    opa[2*DAB] = g1_q.ba.x; opb[2*DAB] = g1_q.ba.x; opa[2*DAB+1] = g1_q.ba.y; opb[2*DAB+1] = g1_q.ba.y;
    opa[2*UBC] = g1_q.qc.x; opb[2*UBC] = g1_q.bc.x; opa[2*UBC+1] = g1_q.qc.y; opb[2*UBC+1] = g1_q.bc.y;
    opa[2*VBC] = g1_q.qb.x; opb[2*VBC] = g1_q.cb.x; opa[2*VBC+1] = g1_q.qb.y; opb[2*VBC+1] = g1_q.cb.y;
    opa[2*DBC] = g1_q.cb.x; opb[2*DBC] = g1_q.cb.x; opa[2*DBC+1] = g1_q.cb.y; opb[2*DBC+1] = g1_q.cb.y;
    opa[2*UCA] = g1_q.qa.x; opb[2*UCA] = g1_q.ca.x; opa[2*UCA+1] = g1_q.qa.y; opb[2*UCA+1] = g1_q.ca.y;
    opa[2*VCA] = g1_q.qc.x; opb[2*VCA] = g1_q.ac.x; opa[2*VCA+1] = g1_q.qc.y; opb[2*VCA+1] = g1_q.ac.y;
    opa[2*DCA] = g1_q.ac.x; opb[2*DCA] = g1_q.ac.x; opa[2*DCA+1] = g1_q.ac.y; opb[2*DCA+1] = g1_q.ac.y;
    opa[2*TU]  = g1_q.qb.x; opb[2*TU]  = g1_q.qc.y; opa[2*TU+1]  = g1_q.qb.y; opb[2*TU+1]  = g1_q.qc.x;
    opa[2*TV]  = g1_q.qc.x; opb[2*TV]  = g1_q.qa.y; opa[2*TV+1]  = g1_q.qc.y; opb[2*TV+1]  = g1_q.qa.x;
    opa[2*TW]  = g1_q.qa.x; opb[2*TW]  = g1_q.qb.y; opa[2*TW+1]  = g1_q.qa.y; opb[2*TW+1]  = g1_q.qb.x;
    opa[2*TD]  = g1_q.ba.x; opb[2*TD]  = g1_q.ca.y; opa[2*TD+1]  = g1_q.ba.y; opb[2*TD+1]  = g1_q.ca.x;
  end

  // stage 4: region select
  function automatic logic pos_f(logic signed [SW-1:0] s);
    return !s[SW-1] && (s != '0);
  endfunction

  function automatic logic nonpos_prod_f(logic signed [SW-1:0] t, logic signed [SW-1:0] d);
    return !((t != '0) && (d != '0) && (t[SW-1] == d[SW-1]));
  endfunction

  sel_e sel;

  always_comb begin
    if (g3_q.cnt <= 2'd1) begin
      sel = SEL_VA;
    end else if (g3_q.cnt == 2'd2) begin
      if (!pos_f(sm_q[UAB])) sel = SEL_VB;
      else if (!pos_f(sm_q[VAB])) sel = SEL_VA;
      else sel = SEL_EAB;
    end else begin
      if (!pos_f(sm_q[VAB]) && !pos_f(sm_q[UCA])) sel = SEL_VA;
      else if (!pos_f(sm_q[UAB]) && !pos_f(sm_q[VBC])) sel = SEL_VB;
      else if (!pos_f(sm_q[UBC]) && !pos_f(sm_q[VCA])) sel = SEL_VC;
      else if (pos_f(sm_q[UAB]) && pos_f(sm_q[VAB]) && nonpos_prod_f(sm_q[TW], sm_q[TD]))
        sel = SEL_EAB;
      else if (pos_f(sm_q[UBC]) && pos_f(sm_q[VBC]) && nonpos_prod_f(sm_q[TU], sm_q[TD]))
        sel = SEL_EBC;
      else if (pos_f(sm_q[UCA]) && pos_f(sm_q[VCA]) && nonpos_prod_f(sm_q[TV], sm_q[TD]))
        sel = SEL_ECA;
      else sel = SEL_IN;
    end
  end

  always_comb begin
    inf4_d = '{is_edge: 1'b0, region: REGION_VERTEX, keep: KEEP_A,
               nx: g3_q.ax, ny: g3_q.ay, dx: g3_q.qa.x, dy: g3_q.qa.y};
    u4_d  = sm_q[UAB][SW-2:0];
    v4_d  = sm_q[VAB][SW-2:0];
    dv4_d = sm_q[DAB][SW-2:0];
    c0x_d = g3_q.ax; c0y_d = g3_q.ay; c1x_d = g3_q.bx; c1y_d = g3_q.by;
    case (sel)
      SEL_VA: begin
      end
      SEL_VB: begin
        inf4_d.keep = KEEP_B;
        inf4_d.nx = g3_q.bx; inf4_d.ny = g3_q.by;
        inf4_d.dx = g3_q.qb.x; inf4_d.dy = g3_q.qb.y;
      end
      SEL_VC: begin
        inf4_d.keep = KEEP_C;
        inf4_d.nx = g3_q.cx; inf4_d.ny = g3_q.cy;
        inf4_d.dx = g3_q.qc.x; inf4_d.dy = g3_q.qc.y;
      end
      SEL_EAB: begin
        inf4_d.is_edge = 1'b1; inf4_d.region = REGION_EDGE; inf4_d.keep = KEEP_AB;
        inf4_d.dx = pos_f(sm_q[TW]) ? g3_q.ab.y : g3_q.ba.y;
        inf4_d.dy = pos_f(sm_q[TW]) ? g3_q.ba.x : g3_q.ab.x;
      end
      SEL_EBC: begin
        inf4_d.is_edge = 1'b1; inf4_d.region = REGION_EDGE; inf4_d.keep = KEEP_BC;
        inf4_d.dx = pos_f(sm_q[TU]) ? g3_q.bc.y : g3_q.cb.y;
        inf4_d.dy = pos_f(sm_q[TU]) ? g3_q.cb.x : g3_q.bc.x;
        u4_d = sm_q[UBC][SW-2:0]; v4_d = sm_q[VBC][SW-2:0]; dv4_d = sm_q[DBC][SW-2:0];
        c0x_d = g3_q.bx; c0y_d = g3_q.by; c1x_d = g3_q.cx; c1y_d = g3_q.cy;
      end
      SEL_ECA: begin
        inf4_d.is_edge = 1'b1; inf4_d.region = REGION_EDGE; inf4_d.keep = KEEP_CA;
        inf4_d.dx = pos_f(sm_q[TV]) ? g3_q.ca.y : g3_q.ac.y;
        inf4_d.dy = pos_f(sm_q[TV]) ? g3_q.ac.x : g3_q.ca.x;
        u4_d = sm_q[UCA][SW-2:0]; v4_d = sm_q[VCA][SW-2:0]; dv4_d = sm_q[DCA][SW-2:0];
        c0x_d = g3_q.cx; c0y_d = g3_q.cy; c1x_d = g3_q.ax; c1y_d = g3_q.ay;
      end
      SEL_IN: begin
        inf4_d.region = REGION_INSIDE; inf4_d.keep = KEEP_ALL;
        inf4_d.nx = g3_q.qx; inf4_d.ny = g3_q.qy;
        inf4_d.dx = '0; inf4_d.dy = '0;
      end
      default: begin
      end
    endcase
  end

  logic [NW-1:0] dsh [QB];

  always_comb begin
    for (int i = 0; i < QB; i++) dsh[i] = NW'(dv_q[i]) << (QB - 1 - i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g1_d;
      g2_q <= g1_q;
      g3_q <= g2_q;
      for (int k = 0; k < NP; k++) pr_q[k] <= opa[k] * opb[k];
      for (int j = 0; j < NSUM; j++) begin
        if (j >= TU) sm_q[j] <= SW'(pr_q[2*j]) - SW'(pr_q[2*j+1]);
        else         sm_q[j] <= SW'(pr_q[2*j]) + SW'(pr_q[2*j+1]);
      end
      inf4_q <= inf4_d;
      u4_q <= u4_d; v4_q <= v4_d; dv4_q <= dv4_d;
      c0x_q <= c0x_d; c0y_q <= c0y_d; c1x_q <= c1x_d; c1y_q <= c1y_d;
      // stage 5: weight times coordinate, weight split in two halves
      pp_q[0] <= $signed({1'b0, u4_q[DW-1:0]}) * c0x_q;
      pp_q[1] <= $signed({1'b0, u4_q[SW-2:DW]}) * c0x_q;
      pp_q[2] <= $signed({1'b0, v4_q[DW-1:0]}) * c1x_q;
      pp_q[3] <= $signed({1'b0, v4_q[SW-2:DW]}) * c1x_q;
      pp_q[4] <= $signed({1'b0, u4_q[DW-1:0]}) * c0y_q;
      pp_q[5] <= $signed({1'b0, u4_q[SW-2:DW]}) * c0y_q;
      pp_q[6] <= $signed({1'b0, v4_q[DW-1:0]}) * c1y_q;
      pp_q[7] <= $signed({1'b0, v4_q[SW-2:DW]}) * c1y_q;
      inf5_q <= inf4_q;
      dv5_q <= dv4_q;
      // stage 6: numerators
      numx_q <= NW'(pp_q[0]) + (NW'(pp_q[1]) <<< DW) + NW'(pp_q[2]) + (NW'(pp_q[3]) <<< DW);
      numy_q <= NW'(pp_q[4]) + (NW'(pp_q[5]) <<< DW) + NW'(pp_q[6]) + (NW'(pp_q[7]) <<< DW);
      inf6_q <= inf5_q;
      dv6_q <= dv5_q;
      // stage 7: magnitudes
      remx_q[0] <= numx_q[NW-1] ? NW'(-numx_q) : NW'(numx_q);
      remy_q[0] <= numy_q[NW-1] ? NW'(-numy_q) : NW'(numy_q);
      negx_q[0] <= numx_q[NW-1];
      negy_q[0] <= numy_q[NW-1];
      quox_q[0] <= '0;
      quoy_q[0] <= '0;
      info_q[0] <= inf6_q;
      dv_q[0] <= dv6_q;
      // restoring divider, one quotient bit per stage
      for (int i = 0; i < QB; i++) begin
        if (remx_q[i] >= dsh[i]) begin
          remx_q[i+1] <= remx_q[i] - dsh[i];
          quox_q[i+1] <= quox_q[i] | (CB'(1) << (QB - 1 - i));
        end else begin
          remx_q[i+1] <= remx_q[i];
          quox_q[i+1] <= quox_q[i];
        end
        if (remy_q[i] >= dsh[i]) begin
          remy_q[i+1] <= remy_q[i] - dsh[i];
          quoy_q[i+1] <= quoy_q[i] | (CB'(1) << (QB - 1 - i));
        end else begin
          remy_q[i+1] <= remy_q[i];
          quoy_q[i+1] <= quoy_q[i];
        end
        negx_q[i+1] <= negx_q[i];
        negy_q[i+1] <= negy_q[i];
        info_q[i+1] <= info_q[i];
        if (i < QB - 1) dv_q[i+1] <= dv_q[i];
      end
      // output register
      if (info_q[QB].is_edge) begin
        nx_q <= negx_q[QB] ? $signed(-quox_q[QB]) : $signed(quox_q[QB]);
        ny_q <= negy_q[QB] ? $signed(-quoy_q[QB]) : $signed(quoy_q[QB]);
      end else begin
        nx_q <= info_q[QB].nx;
        ny_q <= info_q[QB].ny;
      end
      dx_q <= info_q[QB].dx;
      dy_q <= info_q[QB].dy;
      rg_q <= info_q[QB].region;
      kp_q <= info_q[QB].keep;
    end
  end

  assign out_o.valid       = v_q[NS-1];
  assign out_o.nearest_x   = nx_q;
  assign out_o.nearest_y   = ny_q;
  assign out_o.direction_x = dx_q;
  assign out_o.direction_y = dy_q;
  assign out_o.region      = rg_q;
  assign out_o.keep_mask   = kp_q;

endmodule
